[hdl/rrb_pkg.sv]
// Shared types and constants for the rotating bilinear resampler.
// Depends on nothing; every other file of the block imports it.
package rrb_pkg;

	localparam int GREY_W      = 15;
	localparam int FRAC_W      = 8;
	localparam int WGT_W       = FRAC_W + 1;
	localparam int GAIN_W      = 16;
	localparam int DATA_W      = 32;
	localparam int CFG_AW      = 5;
	localparam int NUM_BANKS   = 4;
	localparam int ONE         = 256;
	localparam int ROUND_ADD   = 32767;
	localparam int BLEND_SHIFT = 16;
	localparam int PROD1_W     = GREY_W + WGT_W;
	localparam int PROD2_W     = PROD1_W + WGT_W;
	localparam int SUM_W       = PROD2_W + 2;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_LINE_GAIN_LINE = 3'd0;
	localparam reg_idx_t REG_LINE_GAIN_COL  = 3'd1;
	localparam reg_idx_t REG_COL_GAIN_LINE  = 3'd2;
	localparam reg_idx_t REG_COL_GAIN_COL   = 3'd3;
	localparam reg_idx_t REG_ORIGIN_LINE    = 3'd4;
	localparam reg_idx_t REG_ORIGIN_COL     = 3'd5;
	localparam reg_idx_t REG_BACKGROUND     = 3'd6;

	// Mapping gains and background grey.
	typedef struct packed {
		logic signed [GAIN_W-1:0] lgl;
		logic signed [GAIN_W-1:0] lgc;
		logic signed [GAIN_W-1:0] cgl;
		logic signed [GAIN_W-1:0] cgc;
		logic [GREY_W-1:0]        bg;
	} cfg_t;

	// Control leaving the mapping pipeline.
	typedef struct packed {
		logic              valid;
		logic              sample;
		logic [GREY_W-1:0] grey;
		logic [FRAC_W-1:0] fl;
		logic [FRAC_W-1:0] fc;
	} map_ctl_t;

	// Per-bank selection handed to the blender.
	typedef struct packed {
		logic [NUM_BANKS-1:0] in_img;
		logic [NUM_BANKS-1:0] top;
		logic [NUM_BANKS-1:0] left;
		logic [FRAC_W-1:0]    fl;
		logic [FRAC_W-1:0]    fc;
	} blend_sel_t;

endpackage

[hdl/rrb_cfg.sv]
// Register file of the resampler behind an APB-style write/read port.
// Depends on rrb_pkg.
module rrb_cfg import rrb_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_AW-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output cfg_t                         cfg,
	output logic signed [COORD_BITS-1:0] origin_line,
	output logic signed [COORD_BITS-1:0] origin_col
);

	cfg_t                         cfg_q;
	logic signed [COORD_BITS-1:0] origin_line_q;
	logic signed [COORD_BITS-1:0] origin_col_q;
	reg_idx_t                     idx;
	logic                         wr;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lgl     <= GAIN_W'(ONE);
			cfg_q.lgc     <= '0;
			cfg_q.cgl     <= '0;
			cfg_q.cgc     <= GAIN_W'(ONE);
			cfg_q.bg      <= '0;
			origin_line_q <= '0;
			origin_col_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_LINE_GAIN_LINE: cfg_q.lgl     <= pwdata[GAIN_W-1:0];
				REG_LINE_GAIN_COL:  cfg_q.lgc     <= pwdata[GAIN_W-1:0];
				REG_COL_GAIN_LINE:  cfg_q.cgl     <= pwdata[GAIN_W-1:0];
				REG_COL_GAIN_COL:   cfg_q.cgc     <= pwdata[GAIN_W-1:0];
				REG_ORIGIN_LINE:    origin_line_q <= pwdata[COORD_BITS-1:0];
				REG_ORIGIN_COL:     origin_col_q  <= pwdata[COORD_BITS-1:0];
				REG_BACKGROUND:     cfg_q.bg      <= pwdata[GREY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LINE_GAIN_LINE: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.lgl};
			REG_LINE_GAIN_COL:  prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.lgc};
			REG_COL_GAIN_LINE:  prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.cgl};
			REG_COL_GAIN_COL:   prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.cgc};
			REG_ORIGIN_LINE:    prdata = {{(DATA_W-COORD_BITS){1'b0}}, origin_line_q};
			REG_ORIGIN_COL:     prdata = {{(DATA_W-COORD_BITS){1'b0}}, origin_col_q};
			REG_BACKGROUND:     prdata = {{(DATA_W-GREY_W){1'b0}}, cfg_q.bg};
			default:            prdata = '0;
		endcase
	end

	assign cfg         = cfg_q;
	assign origin_line = origin_line_q;
	assign origin_col  = origin_col_q;

endmodule

[hdl/rrb_map.sv]
// Four-stage coordinate mapping: origin offset, gain products, sums, floor and fraction.
// Depends on rrb_pkg.
module rrb_map import rrb_pkg::*; #(
	parameter int COORD_BITS = 12,
	localparam int WW = COORD_BITS + 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] line,
	input  logic signed [COORD_BITS-1:0] col,
	input  logic [GREY_W-1:0]            grey_in,
	input  cfg_t                         cfg,
	input  logic signed [COORD_BITS-1:0] origin_line,
	input  logic signed [COORD_BITS-1:0] origin_col,
	output map_ctl_t                     ctl_s4,
	output logic signed [WW-1:0]         lq_s4,
	output logic signed [WW-1:0]         cq_s4
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + GAIN_W;
	localparam int SW = PW + 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic                         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [GREY_W-1:0]            grey_s1, grey_s2, grey_s3, grey_s4;
	logic signed [COORD_BITS-1:0] line_s1, line_s2, line_s3;
	logic signed [COORD_BITS-1:0] col_s1, col_s2, col_s3;
	logic signed [DW-1:0]         dl_s1, dc_s1;
	logic signed [PW-1:0]         pll_s2, plc_s2, pcl_s2, pcc_s2;
	logic signed [SW-1:0]         l_s3, c_s3;
	logic [FRAC_W-1:0]            fl_s4, fc_s4;
	logic signed [WW-1:0]         whole_l, whole_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Floor of the Q8 position is an arithmetic shift; the low byte is the fraction.
	assign whole_l = WW'($signed(l_s3[SW-1:FRAC_W])) + WW'(origin_line);
	assign whole_c = WW'($signed(c_s3[SW-1:FRAC_W])) + WW'(origin_col);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd;
			grey_s1 <= grey_in;
			line_s1 <= line;
			col_s1  <= col;
			dl_s1   <= DW'(line) - DW'(origin_line);
			dc_s1   <= DW'(col) - DW'(origin_col);

			cmd_s2  <= cmd_s1;
			grey_s2 <= grey_s1;
			line_s2 <= line_s1;
			col_s2  <= col_s1;
			pll_s2  <= PW'(dl_s1) * PW'($signed(cfg.lgl));
			plc_s2  <= PW'(dc_s1) * PW'($signed(cfg.lgc));
			pcl_s2  <= PW'(dl_s1) * PW'($signed(cfg.cgl));
			pcc_s2  <= PW'(dc_s1) * PW'($signed(cfg.cgc));

			cmd_s3  <= cmd_s2;
			grey_s3 <= grey_s2;
			line_s3 <= line_s2;
			col_s3  <= col_s2;
			l_s3    <= SW'(pll_s2) + SW'(plc_s2);
			c_s3    <= SW'(pcl_s2) + SW'(pcc_s2);

			// A load carries its own pixel position in the same registers.
			cmd_s4  <= cmd_s3;
			grey_s4 <= grey_s3;
			lq_s4   <= cmd_s3 ? whole_l : WW'(line_s3);
			cq_s4   <= cmd_s3 ? whole_c : WW'(col_s3);
			fl_s4   <= l_s3[FRAC_W-1:0];
			fc_s4   <= c_s3[FRAC_W-1:0];
		end
	end

	assign ctl_s4.valid  = valid_s4;
	assign ctl_s4.sample = cmd_s4;
	assign ctl_s4.grey   = grey_s4;
	assign ctl_s4.fl     = fl_s4;
	assign ctl_s4.fc     = fc_s4;

endmodule

[hdl/rrb_bank.sv]
// One parity bank of the source image: one write port, one registered read port.
// Depends on rrb_pkg.
module rrb_bank import rrb_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     raddr,
	output logic [GREY_W-1:0] rdata,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [GREY_W-1:0] wdata
);

	logic [GREY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/rrb_blend.sv]
// Bilinear blend of the four bank outputs: two multiplier stages, then the rounded sum.
// Depends on rrb_pkg.
module rrb_blend import rrb_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  blend_sel_t        sel_s5,
	input  logic [GREY_W-1:0] rdata_s5 [NUM_BANKS],
	input  logic [GREY_W-1:0] bg,
	output logic [GREY_W-1:0] grey
);

	logic [GREY_W-1:0]  val   [NUM_BANKS];
	logic [WGT_W-1:0]   hw    [NUM_BANKS];
	logic [PROD1_W-1:0] m1_s6 [NUM_BANKS];
	logic [WGT_W-1:0]   vw_s6 [NUM_BANKS];
	logic [PROD2_W-1:0] m2_s7 [NUM_BANKS];
	logic [SUM_W-1:0]   sum;

	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			val[b] = sel_s5.in_img[b] ? rdata_s5[b] : bg;
			hw[b]  = sel_s5.left[b] ? (WGT_W'(ONE) - WGT_W'(sel_s5.fc)) : WGT_W'(sel_s5.fc);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				m1_s6[b] <= PROD1_W'(val[b]) * PROD1_W'(hw[b]);
				vw_s6[b] <= sel_s5.top[b] ? (WGT_W'(ONE) - WGT_W'(sel_s5.fl))
				                          : WGT_W'(sel_s5.fl);
				m2_s7[b] <= PROD2_W'(m1_s6[b]) * PROD2_W'(vw_s6[b]);
			end
		end
	end

	// The weights sum to 65536, so the quotient always fits the grey width.
	assign sum = SUM_W'(m2_s7[0]) + SUM_W'(m2_s7[1]) + SUM_W'(m2_s7[2])
	           + SUM_W'(m2_s7[3]) + SUM_W'(ROUND_ADD);
	assign grey = sum[BLEND_SHIFT+GREY_W-1:BLEND_SHIFT];

endmodule

[hdl/rotate_resample_bilinear.sv]
// Rotating bilinear resampler. Source pixels are loaded with cmd low; a request with
// cmd high names an output pixel and yields one result: the bilinear grey of the four
// source neighbours of its inverse-mapped position, with that position and its fractions.
// Both streams are valid/ready channels; configuration goes through an APB-style port
// whose pready is always high, and should be written only while the block is idle.
// Throughput is one request per cycle, loads and samples alike: the image lies in four
// banks split by line and column parity, so the four neighbours are read together,
// one from each bank, and a load writes one bank in the same stage.
// A result is valid after the mapping, memory read, blend and output registers.
// When the receiver stalls, the finished result waits in the output register and the
// pipeline keeps taking requests until a result stands directly behind it; then
// in_ready drops and the whole pipeline holds, memory read registers included.
// Reset clears the pipeline valid flags and sets the registers to an identity mapping;
// the image store is not cleared, and pixels must be loaded before they are sampled.
// Depends on rrb_pkg, rrb_cfg, rrb_map, rrb_bank and rrb_blend.
module rotate_resample_bilinear import rrb_pkg::*; #(
	parameter int IMAGE_SIDE = 128,
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_AW-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] line,
	input  logic signed [COORD_BITS-1:0] col,
	input  logic [GREY_W-1:0]            grey_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [GREY_W-1:0]            grey_out,
	output logic signed [COORD_BITS:0]   src_line,
	output logic signed [COORD_BITS:0]   src_col,
	output logic [FRAC_W-1:0]            line_frac,
	output logic [FRAC_W-1:0]            col_frac,
	output logic                         all_inside
);

	// Each bank holds every second line and every second column.
	localparam int HALF       = (IMAGE_SIDE + 1) / 2;
	localparam int BANK_DEPTH = HALF * HALF;
	localparam int ABW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CW         = $clog2(IMAGE_SIDE);
	localparam int AXW        = 2 * CW + 1;
	localparam int WW         = COORD_BITS + 11;
	localparam int SRC_W      = COORD_BITS + 1;

	localparam logic signed [WW-1:0] SAT_HI = WW'((1 << COORD_BITS) - 1);
	localparam logic signed [WW-1:0] SAT_LO = WW'(-(1 << COORD_BITS));

	cfg_t                         cfg;
	logic signed [COORD_BITS-1:0] origin_line;
	logic signed [COORD_BITS-1:0] origin_col;
	map_ctl_t                     ctl_s4;
	logic signed [WW-1:0]         lq_s4, cq_s4;
	logic                         adv;

	logic signed [WW-1:0]  nb_line [NUM_BANKS];
	logic signed [WW-1:0]  nb_col  [NUM_BANKS];
	logic [ABW-1:0]        bank_a  [NUM_BANKS];
	logic [NUM_BANKS-1:0]  bank_in;
	logic [NUM_BANKS-1:0]  bank_we;
	logic [GREY_W-1:0]     rdata_s5 [NUM_BANKS];
	blend_sel_t            sel_d;
	blend_sel_t            sel_s5;
	logic [GREY_W-1:0]     grey_s7;

	logic                    valid_s5, valid_s6, valid_s7;
	logic signed [SRC_W-1:0] src_line_s5, src_line_s6, src_line_s7;
	logic signed [SRC_W-1:0] src_col_s5, src_col_s6, src_col_s7;
	logic [FRAC_W-1:0]       fl_s6, fl_s7, fc_s6, fc_s7;
	logic                    all_in_s6, all_in_s7;

	logic                    out_valid_q;
	logic [GREY_W-1:0]       grey_out_q;
	logic signed [SRC_W-1:0] src_line_q, src_col_q;
	logic [FRAC_W-1:0]       line_frac_q, col_frac_q;
	logic                    all_inside_q;

	function automatic logic on_image(input logic signed [WW-1:0] v);
		return (v >= WW'(0)) && (v < WW'(IMAGE_SIDE));
	endfunction

	function automatic logic [ABW-1:0] half_addr(input logic signed [WW-1:0] v,
	                                             input logic signed [WW-1:0] h);
		logic [CW-1:0] hr;
		logic [CW-1:0] hc;
		hr = v[CW-1:0] >> 1;
		hc = h[CW-1:0] >> 1;
		return ABW'(AXW'(hr) * AXW'(HALF) + AXW'(hc));
	endfunction

	function automatic logic signed [SRC_W-1:0] saturate(input logic signed [WW-1:0] v);
		if (v > SAT_HI) begin
			return SRC_W'(SAT_HI);
		end else if (v < SAT_LO) begin
			return SRC_W'(SAT_LO);
		end
		return SRC_W'(v);
	endfunction

	// The pipeline moves as one; it stops only when a result in the last stage has
	// nowhere to go because the output register is still waiting to be taken.
	assign adv      = !valid_s7 || !out_valid_q || out_ready;
	assign in_ready = adv;
	assign pready   = 1'b1;

	rrb_cfg #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.cfg         (cfg),
		.origin_line (origin_line),
		.origin_col  (origin_col)
	);

	rrb_map #(
		.COORD_BITS (COORD_BITS)
	) u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.cmd         (cmd),
		.line        (line),
		.col         (col),
		.grey_in     (grey_in),
		.cfg         (cfg),
		.origin_line (origin_line),
		.origin_col  (origin_col),
		.ctl_s4      (ctl_s4),
		.lq_s4       (lq_s4),
		.cq_s4       (cq_s4)
	);

	// Stage five: each bank serves whichever neighbour has its line and column parity.
	// A load writes here too, in the same stage in which samples read, so a sample that
	// follows a load always finds the new pixel and no forwarding is needed.
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam bit PY = (b >= 2);
		localparam bit PX = ((b % 2) == 1);

		assign nb_line[b] = (lq_s4[0] == PY) ? lq_s4 : lq_s4 + WW'(1);
		assign nb_col[b]  = (cq_s4[0] == PX) ? cq_s4 : cq_s4 + WW'(1);
		assign bank_in[b] = on_image(nb_line[b]) && on_image(nb_col[b]);
		assign bank_a[b]  = half_addr(nb_line[b], nb_col[b]);
		assign bank_we[b] = adv && ctl_s4.valid && !ctl_s4.sample && bank_in[b]
		                  && (lq_s4[0] == PY) && (cq_s4[0] == PX);

		assign sel_d.in_img[b] = bank_in[b];
		assign sel_d.top[b]    = (lq_s4[0] == PY);
		assign sel_d.left[b]   = (cq_s4[0] == PX);

		rrb_bank #(
			.DEPTH (BANK_DEPTH),
			.AW    (ABW)
		) u_bank (
			.clk   (clk),
			.rd_en (adv),
			.raddr (bank_a[b]),
			.rdata (rdata_s5[b]),
			.we    (bank_we[b]),
			.waddr (bank_a[b]),
			.wdata (ctl_s4.grey)
		);
	end

	assign sel_d.fl = ctl_s4.fl;
	assign sel_d.fc = ctl_s4.fc;

	rrb_blend u_blend (
		.clk      (clk),
		.adv      (adv),
		.sel_s5   (sel_s5),
		.rdata_s5 (rdata_s5),
		.bg       (cfg.bg),
		.grey     (grey_s7)
	);

	// Only samples travel past the memory stage; loads end there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= ctl_s4.valid && ctl_s4.sample;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Position outputs saturate, while the neighbour lookup above used the full value.
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s5      <= sel_d;
			src_line_s5 <= saturate(lq_s4);
			src_col_s5  <= saturate(cq_s4);

			src_line_s6 <= src_line_s5;
			src_col_s6  <= src_col_s5;
			fl_s6       <= sel_s5.fl;
			fc_s6       <= sel_s5.fc;
			all_in_s6   <= &sel_s5.in_img;

			src_line_s7 <= src_line_s6;
			src_col_s7  <= src_col_s6;
			fl_s7       <= fl_s6;
			fc_s7       <= fc_s6;
			all_in_s7   <= all_in_s6;
		end
	end

	// Output register: refilled whenever it is empty or its result is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s7) begin
			grey_out_q   <= grey_s7;
			src_line_q   <= src_line_s7;
			src_col_q    <= src_col_s7;
			line_frac_q  <= fl_s7;
			col_frac_q   <= fc_s7;
			all_inside_q <= all_in_s7;
		end
	end

	assign out_valid  = out_valid_q;
	assign grey_out   = grey_out_q;
	assign src_line   = src_line_q;
	assign src_col    = src_col_q;
	assign line_frac  = line_frac_q;
	assign col_frac   = col_frac_q;
	assign all_inside = all_inside_q;

`ifndef NO_ASSERTIONS
	// A bank write comes only from a load in stage four, and it touches exactly one bank.
	assert property (@(posedge clk) disable iff (!arst_n)
		(|bank_we) |-> (ctl_s4.valid && !ctl_s4.sample && $onehot(bank_we)))
		else $error("bank write without a single load in stage four");

	// A result held behind a stalled output must still be there next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && valid_s7) |=> (out_valid && valid_s7))
		else $error("result lost while the receiver stalls");

	// A new result appears only out of a full last pipeline stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s7))
		else $error("output valid rose without a result in the last stage");
`endif

endmodule
